### hdl/text_console_glyph_writer_assert.svh
// Assertion macros for the checker file.
`ifndef TEXT_CONSOLE_GLYPH_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_GLYPH_WRITER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define TCGW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tcgw assertion failed");

// Next-cycle implication, disabled while reset is low.
`define TCGW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tcgw assertion failed");

`endif

### hdl/tcgw_pkg.sv
package tcgw_pkg;

  // Glyph geometry
  localparam int GLYPH_ROWS = 8;
  localparam int ROW_W      = (GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 1;

  // Field widths
  localparam int CODE_W = 8;
  localparam int CELL_W = 7;
  localparam int FONT_W = 14;
  localparam int BMP_W  = 18;
  localparam int CFG_W  = 12;
  localparam int IDX_W  = 3;

  // Job queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int QPTR_W  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  // Character codes
  localparam logic [CODE_W-1:0] CH_LF    = 8'd10;
  localparam logic [CODE_W-1:0] CH_CR    = 8'd13;
  localparam logic [CODE_W-1:0] CH_SPACE = 8'd32;

  // Row operation actions
  localparam logic ACT_COPY   = 1'b0;
  localparam logic ACT_INVERT = 1'b1;

  typedef enum logic [1:0] {
    OP_PUT  = 2'd0,
    OP_SET  = 2'd1,
    OP_INV  = 2'd2,
    OP_DRAW = 2'd3
  } opcode_e;

  typedef enum logic [IDX_W-1:0] {
    REG_COLUMNS     = 3'd0,
    REG_ROWS        = 3'd1,
    REG_ROW_BYTES   = 3'd2,
    REG_CHAR_STRIDE = 3'd3,
    REG_FONT_MODULO = 3'd4
  } cfg_reg_e;

  // Reset values of the configuration registers
  localparam logic [7:0]  RST_COLUMNS     = 8'd40;
  localparam logic [7:0]  RST_ROWS        = 8'd32;
  localparam logic [8:0]  RST_ROW_BYTES   = 9'd40;
  localparam logic [11:0] RST_CHAR_STRIDE = 12'd320;
  localparam logic [10:0] RST_FONT_MODULO = 11'd192;

  typedef struct packed {
    logic [7:0]  columns;
    logic [7:0]  rows;
    logic [8:0]  row_bytes;
    logic [11:0] char_row_stride;
    logic [10:0] font_modulo;
  } cfg_t;

  // One glyph job: base offsets of row zero
  typedef struct packed {
    logic              invert;
    logic [FONT_W-1:0] font_base;
    logic [BMP_W-1:0]  bmp_base;
  } job_t;

endpackage

### hdl/tcgw_intf.sv
// Command channel
interface tcgw_cmd_if;
  import tcgw_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        opcode;
  logic [CODE_W-1:0] char_code;
  logic [CELL_W-1:0] cell_x;
  logic [CELL_W-1:0] cell_y;

  modport source (output valid, opcode, char_code, cell_x, cell_y, input ready);
  modport sink   (input valid, opcode, char_code, cell_x, cell_y, output ready);
endinterface

// Row operation channel
interface tcgw_op_if;
  import tcgw_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     action;
  logic signed [FONT_W-1:0] font_offset;
  logic [BMP_W-1:0]         bitmap_offset;
  logic                     last;

  modport source (output valid, action, font_offset, bitmap_offset, last, input ready);
  modport sink   (input valid, action, font_offset, bitmap_offset, last, output ready);
endinterface

// Configuration write channel
interface tcgw_cfg_if;
  import tcgw_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] reg_index;
  logic [CFG_W-1:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

### hdl/tcgw_front.sv
module tcgw_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tcgw_pkg::cfg_t cfg_i,
  tcgw_cmd_if.sink       cmd_i,
  input  logic           q_full_i,
  output logic           push_o,
  output tcgw_pkg::job_t job_o
);
  import tcgw_pkg::*;

  logic [CELL_W-1:0] col_q, col_d;
  logic [CELL_W-1:0] line_q, line_d;
  logic              accept;
  logic              emit;
  logic              glyph_inv;
  logic              printable;
  logic [CELL_W:0]   col_inc, line_inc;
  logic [CELL_W-1:0] cell_col, cell_line;
  logic [CODE_W-1:0] glyph_code;
  logic [18:0]       line_prod;

  assign cmd_i.ready = !q_full_i;
  assign accept      = cmd_i.valid && cmd_i.ready;

  assign printable = (cmd_i.char_code[CODE_W-1] == 1'b0) && (cmd_i.char_code >= CH_SPACE);
  assign col_inc   = {1'b0, col_q} + 8'd1;
  assign line_inc  = {1'b0, line_q} + 8'd1;

  // Classify the command, pick the target cell and the next cursor
  always_comb begin
    emit       = 1'b0;
    col_d      = col_q;
    line_d     = line_q;
    cell_col   = col_q;
    cell_line  = line_q;
    glyph_code = cmd_i.char_code;
    glyph_inv  = ACT_COPY;
    unique case (opcode_e'(cmd_i.opcode))
      OP_PUT: begin
        if (cmd_i.char_code == CH_CR) begin
          // carriage return: no effect
        end else if (cmd_i.char_code == CH_LF) begin
          col_d  = '0;
          line_d = (line_inc >= cfg_i.rows) ? '0 : line_inc[CELL_W-1:0];
        end else if (printable) begin
          emit = 1'b1;
          if (col_inc >= cfg_i.columns) begin
            col_d  = '0;
            line_d = (line_inc >= cfg_i.rows) ? '0 : line_inc[CELL_W-1:0];
          end else begin
            col_d = col_inc[CELL_W-1:0];
          end
        end
      end
      OP_SET: begin
        col_d  = cmd_i.cell_x;
        line_d = cmd_i.cell_y;
      end
      OP_INV: begin
        emit       = 1'b1;
        glyph_code = '0;
        glyph_inv  = ACT_INVERT;
      end
      OP_DRAW: begin
        emit      = 1'b1;
        cell_col  = cmd_i.cell_x;
        cell_line = cmd_i.cell_y;
      end
      default: ;
    endcase
  end

  // Base offsets of row zero
  assign line_prod = 19'(cfg_i.char_row_stride) * 19'(cell_line);
  assign job_o.invert    = glyph_inv;
  assign job_o.bmp_base  = line_prod[BMP_W-1:0] + BMP_W'(cell_col);
  assign job_o.font_base = {{(FONT_W-CODE_W){glyph_code[CODE_W-1]}}, glyph_code}
                           - FONT_W'(CH_SPACE);

  assign push_o = accept && emit;

  // Cursor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      line_q <= '0;
    end else if (accept) begin
      col_q  <= col_d;
      line_q <= line_d;
    end
  end

endmodule

### hdl/tcgw_queue.sv
module tcgw_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tcgw_pkg::job_t job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output tcgw_pkg::job_t job_o
);
  import tcgw_pkg::*;

  job_t              mem_q [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_pop;

  assign full_o  = (cnt_q == QCNT_W'(Q_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  // Pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

### hdl/tcgw_back.sv
module tcgw_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tcgw_pkg::cfg_t cfg_i,
  input  logic           job_valid_i,
  input  tcgw_pkg::job_t job_i,
  output logic           job_pop_o,
  tcgw_op_if.source      op_o
);
  import tcgw_pkg::*;

  // Working glyph
  logic              busy_q, busy_d;
  logic              inv_q;
  logic [FONT_W-1:0] fo_q;
  logic [BMP_W-1:0]  bo_q;
  logic [ROW_W-1:0]  row_q;
  // Output register
  logic              vld_q;
  logic              act_q;
  logic [FONT_W-1:0] font_q;
  logic [BMP_W-1:0]  bmp_q;
  logic              last_q;

  logic advance;
  logic last_row;
  logic step;
  logic load;

  assign advance   = !vld_q || op_o.ready;
  assign last_row  = (row_q == ROW_W'(GLYPH_ROWS - 1));
  assign step      = advance && busy_q;
  assign load      = job_valid_i && (!busy_q || (step && last_row));
  assign job_pop_o = load;

  always_comb begin
    busy_d = busy_q;
    if (load) begin
      busy_d = 1'b1;
    end else if (step && last_row) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      vld_q  <= 1'b0;
    end else begin
      busy_q <= busy_d;
      if (advance) begin
        vld_q <= busy_q;
      end
    end
  end

  // Row sequencer: offsets step by font modulo and row bytes
  always_ff @(posedge clk_i) begin
    if (load) begin
      inv_q <= job_i.invert;
      fo_q  <= job_i.font_base;
      bo_q  <= job_i.bmp_base;
      row_q <= '0;
    end else if (step) begin
      fo_q  <= fo_q + FONT_W'(cfg_i.font_modulo);
      bo_q  <= bo_q + BMP_W'(cfg_i.row_bytes);
      row_q <= row_q + 1'b1;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (step) begin
      act_q  <= inv_q;
      font_q <= (inv_q == ACT_INVERT) ? '0 : fo_q;
      bmp_q  <= bo_q;
      last_q <= last_row;
    end
  end

  assign op_o.valid         = vld_q;
  assign op_o.action        = act_q;
  assign op_o.font_offset   = $signed(font_q);
  assign op_o.bitmap_offset = bmp_q;
  assign op_o.last          = last_q;

endmodule

### hdl/text_console_glyph_writer.sv
// Channel | Dir | Payload                                          | Moves
// cmd_i   | in  | opcode, char_code, cell_x, cell_y                | one command request
// op_o    | out | action, font_offset, bitmap_offset, last         | one row operation
// cfg_i   | in  | reg_index, wdata                                 | one register write
//
// A drawn glyph is 8 row operations, one row operation per cycle while op_o is ready,
// set by the row sequencer in the back end; commands that draw nothing push no job.
// First row operation passes the job queue, the working glyph and the output register.
// Reset clears the cursor to the top left, loads register defaults, empties the queue.
// A stalled op_o holds its row; the front keeps accepting until the 2-entry job queue fills.
module text_console_glyph_writer (
  input  logic      clk_i,
  input  logic      rst_ni,
  tcgw_cmd_if.sink  cmd_i,
  tcgw_op_if.source op_o,
  tcgw_cfg_if.sink  cfg_i
);
  import tcgw_pkg::*;

  cfg_t cfg_q;
  logic q_full;
  logic q_push;
  job_t q_in;
  logic q_valid;
  logic q_pop;
  job_t q_out;

  // Configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.columns         <= RST_COLUMNS;
      cfg_q.rows            <= RST_ROWS;
      cfg_q.row_bytes       <= RST_ROW_BYTES;
      cfg_q.char_row_stride <= RST_CHAR_STRIDE;
      cfg_q.font_modulo     <= RST_FONT_MODULO;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_reg_e'(cfg_i.reg_index))
        REG_COLUMNS:     cfg_q.columns         <= cfg_i.wdata[7:0];
        REG_ROWS:        cfg_q.rows            <= cfg_i.wdata[7:0];
        REG_ROW_BYTES:   cfg_q.row_bytes       <= cfg_i.wdata[8:0];
        REG_CHAR_STRIDE: cfg_q.char_row_stride <= cfg_i.wdata[11:0];
        REG_FONT_MODULO: cfg_q.font_modulo     <= cfg_i.wdata[10:0];
        default: ;
      endcase
    end
  end

  tcgw_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .cmd_i    (cmd_i),
    .q_full_i (q_full),
    .push_o   (q_push),
    .job_o    (q_in)
  );

  tcgw_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .job_o   (q_out)
  );

  tcgw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (q_valid),
    .job_i       (q_out),
    .job_pop_o   (q_pop),
    .op_o        (op_o)
  );

endmodule

### hdl/tcgw_checker.sv
`include "text_console_glyph_writer_assert.svh"

module tcgw_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        op_valid_i,
  input logic        op_ready_i,
  input logic        op_action_i,
  input logic [13:0] op_font_offset_i,
  input logic [17:0] op_bitmap_offset_i,
  input logic        op_last_i
);

  // Stalled row operation holds
  `TCGW_ASSERT_NEXT(a_op_hold, clk_i, rst_ni, op_valid_i && !op_ready_i, op_valid_i && $stable(op_bitmap_offset_i) && $stable(op_last_i))

  // Invert rows carry no font offset
  `TCGW_ASSERT_NOW(a_inv_font_zero, clk_i, rst_ni, op_valid_i && op_action_i, op_font_offset_i == 14'd0)

  // Rows of one glyph come without gaps
  `TCGW_ASSERT_NEXT(a_glyph_no_gap, clk_i, rst_ni, op_valid_i && op_ready_i && !op_last_i, op_valid_i)

  // Action stays the same within one glyph
  `TCGW_ASSERT_NEXT(a_glyph_action, clk_i, rst_ni, op_valid_i && op_ready_i && !op_last_i, op_action_i == $past(op_action_i))

endmodule

bind text_console_glyph_writer tcgw_checker u_tcgw_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .op_valid_i         (op_o.valid),
  .op_ready_i         (op_o.ready),
  .op_action_i        (op_o.action),
  .op_font_offset_i   (op_o.font_offset),
  .op_bitmap_offset_i (op_o.bitmap_offset),
  .op_last_i          (op_o.last)
);

### bench/tcgw_row_op_checker.sv
// Watches the command, config and row op channels, predicts the row ops
// of every accepted command and compares them in order with what comes out.
module tcgw_row_op_checker (
  input  logic clk_i,
  input  logic rst_ni,
  tcgw_cmd_if  cmd_i,
  tcgw_op_if   op_i,
  tcgw_cfg_if  cfg_i,
  output int   pending_o,
  output int   fail_count_o
);
  import tcgw_pkg::*;

  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic                     action;
    logic signed [FONT_W-1:0] font_offset;
    logic [BMP_W-1:0]         bitmap_offset;
    logic                     last;
  } row_op_t;

  // Shadow copy of the geometry registers
  logic [7:0]  cols_cfg;
  logic [7:0]  lines_cfg;
  logic [8:0]  pitch_cfg;
  logic [11:0] stride_cfg;
  logic [10:0] fmod_cfg;

  // Text cursor
  logic [CELL_W-1:0] cur_col;
  logic [CELL_W-1:0] cur_line;

  row_op_t row_ops_due[$];
  row_op_t want;
  int      errors = 0;

  // Column back to zero, next line, wrap to the top past the last line
  task automatic advance_line();
    int y;
    y = int'(cur_line) + 1;
    cur_col = '0;
    cur_line = (y >= int'(lines_cfg)) ? '0 : CELL_W'(y);
  endtask

  // Step right, wrap to the next line at the end of a line
  task automatic advance_col();
    int x;
    x = int'(cur_col) + 1;
    if (x >= int'(cols_cfg)) begin
      advance_line();
    end else begin
      cur_col = CELL_W'(x);
    end
  endtask

  // Expected row ops of one glyph cell
  task automatic queue_glyph_rows(input logic action, input logic [CODE_W-1:0] code,
                                  input logic [CELL_W-1:0] col,
                                  input logic [CELL_W-1:0] line);
    logic [FONT_W-1:0] base;
    logic [31:0]       bmp;
    row_op_t           e;
    // signed character code minus the first printable code
    base = {{(FONT_W-CODE_W){code[CODE_W-1]}}, code} - FONT_W'(CH_SPACE);
    for (int r = 0; r < GLYPH_ROWS; r++) begin
      bmp = 32'(stride_cfg) * 32'(line) + 32'(col) + 32'(r) * 32'(pitch_cfg);
      e.action = action;
      e.font_offset = (action == ACT_INVERT) ? '0 : base + FONT_W'(32'(r) * 32'(fmod_cfg));
      e.bitmap_offset = bmp[BMP_W-1:0];
      e.last = (r == GLYPH_ROWS - 1);
      row_ops_due.push_back(e);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_cfg = RST_COLUMNS;
      lines_cfg = RST_ROWS;
      pitch_cfg = RST_ROW_BYTES;
      stride_cfg = RST_CHAR_STRIDE;
      fmod_cfg = RST_FONT_MODULO;
      cur_col = '0;
      cur_line = '0;
      row_ops_due.delete();
      pending_o <= 0;
      fail_count_o <= errors;
    end else begin
      // register writes; unknown indexes are ignored
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.reg_index)
          REG_COLUMNS:     cols_cfg = cfg_i.wdata[7:0];
          REG_ROWS:        lines_cfg = cfg_i.wdata[7:0];
          REG_ROW_BYTES:   pitch_cfg = cfg_i.wdata[8:0];
          REG_CHAR_STRIDE: stride_cfg = cfg_i.wdata[11:0];
          REG_FONT_MODULO: fmod_cfg = cfg_i.wdata[10:0];
          default: ;
        endcase
      end

      // command requests
      if (cmd_i.valid && cmd_i.ready) begin
        case (cmd_i.opcode)
          OP_PUT: begin
            // newline moves down; CR, other control codes and negative codes drop
            if (cmd_i.char_code == CH_LF) begin
              advance_line();
            end else if (cmd_i.char_code != CH_CR && cmd_i.char_code >= CH_SPACE &&
                         !cmd_i.char_code[CODE_W-1]) begin
              queue_glyph_rows(ACT_COPY, cmd_i.char_code, cur_col, cur_line);
              advance_col();
            end
          end
          OP_SET: begin
            cur_col = cmd_i.cell_x;
            cur_line = cmd_i.cell_y;
          end
          OP_INV: begin
            queue_glyph_rows(ACT_INVERT, '0, cur_col, cur_line);
          end
          default: begin
            queue_glyph_rows(ACT_COPY, cmd_i.char_code, cmd_i.cell_x, cmd_i.cell_y);
          end
        endcase
      end

      // row ops leaving the block, oldest expectation first
      if (op_i.valid && op_i.ready) begin
        if (row_ops_due.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS) begin
            $display("%0t: row op with none due: action=%0b font=%0d bitmap=%0d last=%0b",
                     $realtime, op_i.action, op_i.font_offset, op_i.bitmap_offset, op_i.last);
          end
        end else begin
          want = row_ops_due.pop_front();
          if (op_i.action !== want.action || op_i.font_offset !== want.font_offset ||
              op_i.bitmap_offset !== want.bitmap_offset || op_i.last !== want.last) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
              $display("%0t: row op mismatch: expected action=%0b font=%0d bitmap=%0d last=%0b",
                       $realtime, want.action, want.font_offset, want.bitmap_offset,
                       want.last);
              $display("%0t:                  got      action=%0b font=%0d bitmap=%0d last=%0b",
                       $realtime, op_i.action, op_i.font_offset, op_i.bitmap_offset,
                       op_i.last);
            end
          end
        end
      end

      pending_o <= row_ops_due.size();
      fail_count_o <= errors;
    end
  end

endmodule

### bench/testbench.sv
module testbench;
  import tcgw_pkg::*;

  localparam int RESET_CYCLES     = 10;
  localparam int SETTLE_CYCLES    = 12;
  localparam int LONG_HOLD_CYCLES = 120;
  localparam int RUN_LIMIT        = 2_000_000;
  // index past the last register, written to check that it changes nothing
  localparam logic [IDX_W-1:0] SPARE_REG = 3'd7;

  logic clk_i;
  logic rst_ni;
  int   ops_pending;
  int   fail_count;
  bit   long_hold_due = 1'b0;
  bit   quiet = 1'b0;
  int   cols_now = RST_COLUMNS;
  int   lines_now = RST_ROWS;

  tcgw_cmd_if cmd_ch ();
  tcgw_op_if  op_ch ();
  tcgw_cfg_if cfg_ch ();

  text_console_glyph_writer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_ch),
    .op_o   (op_ch),
    .cfg_i  (cfg_ch)
  );

  tcgw_row_op_checker row_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd_ch),
    .op_i         (op_ch),
    .cfg_i        (cfg_ch),
    .pending_o    (ops_pending),
    .fail_count_o (fail_count)
  );

  // Clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Hard stop
  initial begin
    #(RUN_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Row op receiver: random ready bursts, one long hold-off, steady at the end
  initial begin : op_sink
    bit held;
    held = 1'b0;
    op_ch.ready <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (long_hold_due && !held) begin
        held = 1'b1;
        op_ch.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
      end
      op_ch.ready <= 1'b1;
      if (quiet) begin
        @(posedge clk_i);
      end else begin
        repeat ($urandom_range(1, ($urandom_range(0, 7) == 0) ? 40 : 8)) @(posedge clk_i);
        op_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end
    end
  end

  // One command request, with an optional idle burst ahead of it
  task automatic send_cmd(input opcode_e op, input logic [CODE_W-1:0] code,
                          input logic [CELL_W-1:0] x, input logic [CELL_W-1:0] y);
    if (!quiet && $urandom_range(0, 9) < 3) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.opcode <= op;
    cmd_ch.char_code <= code;
    cmd_ch.cell_x <= x;
    cmd_ch.cell_y <= y;
    do @(posedge clk_i); while (!cmd_ch.ready);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wdata <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
  endtask

  // Stop sending, wait for every row op, then let the pipeline settle
  task automatic drain();
    cmd_ch.valid <= 1'b0;
    do @(posedge clk_i); while (ops_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_geometry(input int c, input int l, input int p, input int s, input int f,
                              input bit spare);
    write_reg(REG_COLUMNS, CFG_W'(c));
    write_reg(REG_ROWS, CFG_W'(l));
    write_reg(REG_ROW_BYTES, CFG_W'(p));
    write_reg(REG_CHAR_STRIDE, CFG_W'(s));
    write_reg(REG_FONT_MODULO, CFG_W'(f));
    if (spare) begin
      write_reg(SPARE_REG, '1);
    end
    cfg_ch.valid <= 1'b0;
    cols_now = c & 8'hFF;
    lines_now = l & 8'hFF;
  endtask

  // Printable text that walks the cursor across lines, mixed with other commands and noise
  task automatic random_command();
    int pick;
    logic [CODE_W-1:0] code;
    logic [CELL_W-1:0] x;
    logic [CELL_W-1:0] y;
    pick = $urandom_range(0, 99);
    code = CODE_W'($urandom_range(0, 255));
    x = CELL_W'($urandom_range(0, 127));
    y = CELL_W'($urandom_range(0, 127));
    if (pick < 50) begin
      if ($urandom_range(0, 4) != 0) begin
        code = CODE_W'($urandom_range(CH_SPACE, 126));
      end else if ($urandom_range(0, 2) == 0) begin
        code = CH_LF;
      end
      send_cmd(OP_PUT, code, x, y);
    end else if (pick < 60) begin
      // keep the cursor on screen half the time
      if ($urandom_range(0, 1) == 0 && cols_now > 0 && lines_now > 0) begin
        x = CELL_W'($urandom_range(0, ((cols_now > 128) ? 128 : cols_now) - 1));
        y = CELL_W'($urandom_range(0, ((lines_now > 128) ? 128 : lines_now) - 1));
      end
      send_cmd(OP_SET, code, x, y);
    end else if (pick < 72) begin
      send_cmd(OP_INV, code, x, y);
    end else begin
      send_cmd(OP_DRAW, code, x, y);
    end
  endtask

  task automatic run_random(input int n);
    repeat (n) random_command();
    drain();
  endtask

  initial begin : stimulus
    cmd_ch.valid <= 1'b0;
    cmd_ch.opcode <= OP_PUT;
    cmd_ch.char_code <= '0;
    cmd_ch.cell_x <= '0;
    cmd_ch.cell_y <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.reg_index <= REG_COLUMNS;
    cfg_ch.wdata <= '0;
    rst_ni <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(posedge clk_i); while (!rst_ni);

    // Directed, reset geometry
    send_cmd(OP_PUT, 8'd65, '0, '0);
    send_cmd(OP_PUT, CH_SPACE, '0, '0);
    send_cmd(OP_PUT, 8'd127, '0, '0);
    send_cmd(OP_PUT, CH_CR, '0, '0);
    send_cmd(OP_PUT, CH_LF, '0, '0);
    send_cmd(OP_PUT, 8'd0, '0, '0);
    send_cmd(OP_PUT, 8'd31, '0, '0);
    send_cmd(OP_PUT, 8'd128, '0, '0);
    send_cmd(OP_PUT, 8'd255, '0, '0);
    // last cell on screen: wraps back to the top left
    send_cmd(OP_SET, '0, 7'd39, 7'd31);
    send_cmd(OP_PUT, 8'd126, '0, '0);
    // cursor parked off screen
    send_cmd(OP_SET, '0, 7'd127, 7'd127);
    send_cmd(OP_PUT, 8'd90, '0, '0);
    send_cmd(OP_SET, '0, 7'd5, 7'd127);
    send_cmd(OP_PUT, CH_LF, '0, '0);
    send_cmd(OP_INV, 8'hFF, 7'd127, 7'd127);
    // direct draws take any code and leave the cursor alone
    send_cmd(OP_DRAW, 8'd0, 7'd0, 7'd0);
    send_cmd(OP_DRAW, 8'd255, 7'd127, 7'd127);
    send_cmd(OP_DRAW, 8'd128, 7'd64, 7'd3);
    send_cmd(OP_DRAW, CH_LF, 7'd1, 7'd1);
    send_cmd(OP_DRAW, CH_CR, 7'd2, 7'd2);
    send_cmd(OP_SET, '0, 7'd85, 7'd42);
    send_cmd(OP_INV, '0, '0, '0);
    send_cmd(OP_PUT, 8'd97, '0, '0);
    send_cmd(OP_PUT, 8'd98, '0, '0);
    drain();

    // Smallest geometry
    set_geometry(1, 1, 1, 8, 1, 1'b0);
    run_random(25);

    // Largest in-range geometry, with the long receiver hold-off
    set_geometry(128, 128, 256, 2048, 1024, 1'b0);
    long_hold_due = 1'b1;
    run_random(25);

    // Zero counts and full-width register values, offsets overflow
    set_geometry(0, 0, 511, 4095, 2047, 1'b1);
    run_random(20);

    // Oversize counts wrap within the cursor width
    set_geometry($urandom_range(129, 255), $urandom_range(129, 255), $urandom_range(1, 256),
                 $urandom_range(8, 2048), $urandom_range(1, 1024), 1'b0);
    run_random(25);

    // Random in-range geometry, no idling from here on
    quiet = 1'b1;
    set_geometry($urandom_range(1, 128), $urandom_range(1, 128), $urandom_range(1, 256),
                 $urandom_range(8, 2048), $urandom_range(1, 1024), 1'b0);
    run_random(30);

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
